// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/fta_pkg.sv
package fta_pkg;

	// field and state widths
	localparam int TIME_BITS   = 48;
	localparam int ALPHA_BITS  = 16;
	localparam int DELTA_BITS  = 32;
	localparam int FD_BITS     = 24;
	localparam int STEPS_BITS  = 8;
	localparam int ACC_BITS    = 33;
	localparam int DIV_CNT_BITS = $clog2(ALPHA_BITS);

	// stream and config port widths
	localparam int IN_DATA_BITS  = 48;
	localparam int OUT_DATA_BITS = 104;
	localparam int OUT_USER_BITS = 2;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 32;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_DELTA       = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FIXED_DELTA     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_FIXED_STEPS = 2'd2;

	// register reset values
	localparam logic [DELTA_BITS-1:0] MAX_DELTA_RST       = 32'd250000;
	localparam logic [FD_BITS-1:0]    FIXED_DELTA_RST     = 24'd16667;
	localparam logic [STEPS_BITS-1:0] MAX_FIXED_STEPS_RST = 8'd5;

	// status from the step/divide sequencer
	typedef struct packed {
		logic busy;
		logic done;
		logic sat;
	} fta_sts_t;

endpackage

// File: rtl/core/fta_stepper.sv
module fta_stepper import fta_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [ACC_BITS-1:0]     acc_in,
	input  logic [FD_BITS-1:0]      fixed_delta,
	input  logic [STEPS_BITS-1:0]   max_steps,
	output fta_sts_t                sts,
	output logic [STEPS_BITS-1:0]   steps,
	output logic [ALPHA_BITS-1:0]   alpha,
	output logic [FD_BITS-1:0]      acc_out
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_STEP = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]              state_q;
	logic [ACC_BITS-1:0]     acc_q;
	logic [STEPS_BITS-1:0]   steps_q;
	logic [ALPHA_BITS-1:0]   quo_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic                    sat_q;

	logic [ACC_BITS-1:0]     opa;
	logic [ACC_BITS:0]       diff;
	logic                    ge;

	// shared subtract/compare unit: step takeout and restoring division
	always_comb begin
		if (state_q == S_DIV) begin
			opa = {acc_q[ACC_BITS-2:0], 1'b0};
		end else begin
			opa = acc_q;
		end
		diff = {1'b0, opa} - {{(ACC_BITS+1-FD_BITS){1'b0}}, fixed_delta};
		ge   = !diff[ACC_BITS];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					if (!(ge && (steps_q < max_steps))) begin
						if (fixed_delta == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					if (cnt_q == DIV_CNT_BITS'(ALPHA_BITS-1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				acc_q   <= acc_in;
				steps_q <= '0;
				sat_q   <= 1'b0;
				quo_q   <= '0;
				cnt_q   <= '0;
			end
			S_STEP: begin
				if (ge && (steps_q < max_steps)) begin
					acc_q   <= diff[ACC_BITS-1:0];
					steps_q <= steps_q + 1'b1;
				end else if (ge) begin
					// step cap reached with a full step left over
					sat_q <= 1'b1;
					acc_q <= '0;
				end
			end
			S_DIV: begin
				if (ge) begin
					acc_q <= diff[ACC_BITS-1:0];
					quo_q <= {quo_q[ALPHA_BITS-2:0], 1'b1};
				end else begin
					acc_q <= opa;
					quo_q <= {quo_q[ALPHA_BITS-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	// accumulator is only read back at the end of the step phase
	logic [FD_BITS-1:0] acc_keep_q;

	always_ff @(posedge clk) begin
		if (state_q == S_STEP && !(ge && (steps_q < max_steps))) begin
			acc_keep_q <= ge ? '0 : acc_q[FD_BITS-1:0];
		end
	end

	assign sts.busy = (state_q != S_IDLE);
	assign sts.done = (state_q == S_DONE);
	assign sts.sat  = sat_q;
	assign steps    = steps_q;
	assign alpha    = quo_q;
	assign acc_out  = acc_keep_q;

endmodule

// File: rtl/core/fixed_timestep_accumulator.sv
// Fixed-timestep accumulator with a cap on steps per frame.
// Input channel s_*: one timestamp per transaction (now_ticks in s_tdata).
// Output channel m_*: one result transaction per input transaction, in order.
// Config port: cfg_we writes cfg_wdata into the register selected by
// cfg_index (0 max_delta, 1 fixed_delta, 2 max_fixed_steps); write only while
// the block is idle. Indexes beyond the list are ignored.
// Processing: the first timestamp and a stale one go straight from the
// difference step to the output register. Any other is clamped and handed
// to the sequencer, where one subtract/compare unit takes out the fixed steps
// (at most 255), one step per cycle, and then runs a restoring division for
// the 16-bit alpha. With a zero fixed_delta the division is skipped.
// Flow: one transaction at a time; s_tready is high only while the
// sequencer is idle, the cycle after a result is loaded into the output
// register.
// Reset: clears the started flag, times and accumulator and loads the
// register reset values; no output transaction is pending afterward.
// Stall: the result sits in an output register; a new item is accepted
// while it waits, but its own result is held until the register frees up.
module fixed_timestep_accumulator import fta_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [47:0] now_ticks
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// [31:0] delta_ticks, [79:32] elapsed_ticks, [87:80] fixed_steps,
	// [103:88] alpha_frac
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic [OUT_USER_BITS-1:0] m_tuser,   // [0] saturated, [1] stale_time
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	`include "assert_macros.svh"

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIFF  = 3'd1;
	localparam logic [2:0] ST_CLAMP = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;

	logic [2:0]               state_q;
	logic [DELTA_BITS-1:0]    max_delta_q;
	logic [FD_BITS-1:0]       fixed_delta_q;
	logic [STEPS_BITS-1:0]    max_steps_q;

	logic                     started_q;
	logic [TIME_BITS-1:0]     start_time_q;
	logic [TIME_BITS-1:0]     last_time_q;
	logic [FD_BITS-1:0]       acc_q;

	logic [TIME_BITS-1:0]     now_q;
	logic [TIME_BITS-1:0]     diff_q;

	logic [DELTA_BITS-1:0]    res_delta_q;
	logic [TIME_BITS-1:0]     res_elapsed_q;
	logic [STEPS_BITS-1:0]    res_steps_q;
	logic [ALPHA_BITS-1:0]    res_alpha_q;
	logic                     res_sat_q;
	logic                     res_stale_q;

	logic                     m_tvalid_q;
	logic [OUT_DATA_BITS-1:0] m_tdata_q;
	logic [OUT_USER_BITS-1:0] m_tuser_q;

	logic [TIME_BITS:0]       diff_w;
	logic [TIME_BITS-1:0]     elapsed_w;
	logic [DELTA_BITS-1:0]    delta_w;
	logic [ACC_BITS-1:0]      acc_in;
	logic                     out_load;

	fta_sts_t                 sts;
	logic [STEPS_BITS-1:0]    st_steps;
	logic [ALPHA_BITS-1:0]    st_alpha;
	logic [FD_BITS-1:0]       st_acc;

	// frame delta, elapsed time, clamp and accumulator sum
	always_comb begin
		diff_w    = {1'b0, now_q} - {1'b0, last_time_q};
		elapsed_w = now_q - start_time_q;
		if (diff_q > {{(TIME_BITS-DELTA_BITS){1'b0}}, max_delta_q}) begin
			delta_w = max_delta_q;
		end else begin
			delta_w = diff_q[DELTA_BITS-1:0];
		end
		acc_in = {{(ACC_BITS-FD_BITS){1'b0}}, acc_q} + {1'b0, delta_w};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delta_q   <= MAX_DELTA_RST;
			fixed_delta_q <= FIXED_DELTA_RST;
			max_steps_q   <= MAX_FIXED_STEPS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_DELTA:       max_delta_q   <= cfg_wdata[DELTA_BITS-1:0];
				REG_FIXED_DELTA:     fixed_delta_q <= cfg_wdata[FD_BITS-1:0];
				REG_MAX_FIXED_STEPS: max_steps_q   <= cfg_wdata[STEPS_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// shared step/divide sequencer
	fta_stepper u_stepper (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (state_q == ST_CLAMP),
		.acc_in      (acc_in),
		.fixed_delta (fixed_delta_q),
		.max_steps   (max_steps_q),
		.sts         (sts),
		.steps       (st_steps),
		.alpha       (st_alpha),
		.acc_out     (st_acc)
	);

	// control state and timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			started_q    <= 1'b0;
			start_time_q <= '0;
			last_time_q  <= '0;
			acc_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					if (!started_q) begin
						started_q    <= 1'b1;
						start_time_q <= now_q;
						last_time_q  <= now_q;
						state_q      <= ST_FIN;
					end else if (diff_w[TIME_BITS]) begin
						state_q <= ST_FIN;
					end else begin
						last_time_q <= now_q;
						state_q     <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (sts.done) begin
						acc_q   <= st_acc;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// per-item payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				now_q <= s_tdata[TIME_BITS-1:0];
			end
			ST_DIFF: begin
				res_delta_q   <= '0;
				res_elapsed_q <= (started_q && !diff_w[TIME_BITS]) ? elapsed_w : '0;
				res_steps_q   <= '0;
				res_alpha_q   <= '0;
				res_sat_q     <= 1'b0;
				res_stale_q   <= started_q && diff_w[TIME_BITS];
				diff_q        <= diff_w[TIME_BITS-1:0];
			end
			ST_CLAMP: begin
				res_delta_q <= delta_w;
			end
			ST_RUN: begin
				if (sts.done) begin
					res_steps_q <= st_steps;
					res_alpha_q <= st_alpha;
					res_sat_q   <= sts.sat;
				end
			end
			default: begin
			end
		endcase
	end

	// output register
	assign out_load = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {res_alpha_q, res_steps_q, res_elapsed_q, res_delta_q};
			m_tuser_q <= {res_stale_q, res_sat_q};
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// checks
	`ASSERT_IMPLIES(a_ready_idle, clk, arst_n, s_tready, !sts.busy, "accepting while sequencer busy")
	`ASSERT_IMPLIES(a_done_run, clk, arst_n, sts.done, state_q == ST_RUN, "sequencer done outside run")
	`ASSERT_IMPLIES(a_stale_zero, clk, arst_n, m_tvalid && m_tuser[1], (m_tdata == '0) && !m_tuser[0], "stale transaction carries data")
	`ASSERT_NEXT(a_accept_diff, clk, arst_n, s_tvalid && s_tready, state_q == ST_DIFF, "accepted transaction not taken up")

endmodule
